@@ rtl/arq_pkg.sv @@
`timescale 1ns / 1ps
// arq_pkg: shared types and constants of the acknowledgement request queue
// no dependencies; used by arq_cell and ack_request_queue_core

package arq_pkg;

    // request kinds as held in the queue
    typedef enum logic [1:0] {
        KIND_MESSAGE = 2'd0,
        KIND_MODE    = 2'd1,
        KIND_LEVEL   = 2'd2,
        KIND_BRAKE   = 2'd3
    } kind_t;

    // input request types
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_RAISE = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    // granted request, none or kind plus one
    typedef enum logic [2:0] {
        GR_NONE    = 3'd0,
        GR_MESSAGE = 3'd1,
        GR_MODE    = 3'd2,
        GR_LEVEL   = 3'd3,
        GR_BRAKE   = 3'd4
    } grant_t;

    // level acknowledgement indication
    typedef enum logic [1:0] {
        LVL_NONE      = 2'd0,
        LVL_ANNOUNCED = 2'd1,
        LVL_REQUESTED = 2'd2
    } level_t;

    // configuration port
    localparam int          PADDR_WIDTH   = 3;
    localparam int          PDATA_WIDTH   = 32;
    localparam int          HOLDOFF_WIDTH = 16;
    localparam logic [15:0] HOLDOFF_RESET = 16'd1000;
    localparam int          TIME_WIDTH    = 32;

    // level ids with a special meaning
    localparam int LEVEL_ID_ANNOUNCE = 1;
    localparam int LEVEL_ID_REVOKE   = 0;

    // control of one step of the cell row
    typedef struct packed {
        logic  pop;
        logic  push;
        kind_t wr_kind;
    } cell_ctrl_t;

endpackage

@@ rtl/arq_cell.sv @@
`timescale 1ns / 1ps
// arq_cell: one queue slot holding a kind and an id
// shifts toward the head or takes a written entry; uses arq_pkg

module arq_cell #(
    parameter int ID_WIDTH  = 16,
    parameter int IDX_WIDTH = 4,
    parameter int IDX       = 0
) (
    input  logic                   clk,
    input  arq_pkg::cell_ctrl_t    ctrl,
    input  logic [IDX_WIDTH-1:0]   wpos,
    input  logic [ID_WIDTH-1:0]    wr_id,
    input  arq_pkg::kind_t         nbr_kind,
    input  logic [ID_WIDTH-1:0]    nbr_id,
    output arq_pkg::kind_t         kind,
    output logic [ID_WIDTH-1:0]    id
);

    arq_pkg::kind_t        kind_reg;
    arq_pkg::kind_t        kind_next;
    logic [ID_WIDTH-1:0]   id_reg;
    logic [ID_WIDTH-1:0]   id_next;

    // write has priority over the shift from the neighbor
    always_comb
    begin
        kind_next = kind_reg;
        id_next   = id_reg;
        if (ctrl.push && (wpos == IDX_WIDTH'(IDX)))
        begin
            kind_next = ctrl.wr_kind;
            id_next   = wr_id;
        end
        else if (ctrl.pop)
        begin
            kind_next = nbr_kind;
            id_next   = nbr_id;
        end
    end

    // slot contents, no reset
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
    end

    assign kind = kind_reg;
    assign id   = id_reg;

endmodule

@@ rtl/ack_request_queue_core.sv @@
`timescale 1ns / 1ps
// ack_request_queue_core: ordered queue of driver acknowledgement requests
// row of arq_cell slots plus walk control and APB register; uses arq_pkg
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_ready  | req_type ack_kind ack_id time_ms
//  out     | out_valid/out_ready| allowed_kind mode_ack_flag level_ack_state
//          |                    | brake_ack_flag sound_info refresh_messages
//          |                    | pending_count dropped
//  cfg     | psel/penable/pready| paddr pwrite pwdata prdata (holdoff_ms @0)
//
// a raise or clear item walks the cell row, one walk step per queued entry,
// head popped and kept entries pushed at the tail, then finishes in ST_DONE
// a tick item goes straight to ST_DONE; the result sits in an output register
// the next item is taken while a result waits; a finished item stalls only
// when the output register is still full; reset empties the queue at once

module ack_request_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             req_type,
    input  logic [1:0]                             ack_kind,
    input  logic [ID_WIDTH-1:0]                    ack_id,
    input  logic [31:0]                            time_ms,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0]                             allowed_kind,
    output logic                                   mode_ack_flag,
    output logic [1:0]                             level_ack_state,
    output logic                                   brake_ack_flag,
    output logic                                   sound_info,
    output logic                                   refresh_messages,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       pending_count,
    output logic                                   dropped,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [arq_pkg::PADDR_WIDTH-1:0]        paddr,
    input  logic [arq_pkg::PDATA_WIDTH-1:0]        pwdata,
    output logic [arq_pkg::PDATA_WIDTH-1:0]        prdata,
    output logic                                   pready
);

    localparam int IDX_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TICK,
        OP_APPEND,
        OP_REMOVE
    } op_t;

    // control and working state
    state_t                               state_reg, state_next;
    op_t                                  op_reg, op_next;
    arq_pkg::kind_t                       kind_reg, kind_next;
    logic [ID_WIDTH-1:0]                  id_reg, id_next;
    logic [arq_pkg::TIME_WIDTH-1:0]       now_reg, now_next;
    logic [CNT_WIDTH-1:0]                 step_reg, step_next;
    logic [CNT_WIDTH-1:0]                 len_reg, len_next;
    logic                                 kept_reg, kept_next;
    logic                                 found_reg, found_next;

    // architectural state
    logic [CNT_WIDTH-1:0]                 fill_reg, fill_next;
    arq_pkg::grant_t                      granted_reg, granted_next;
    logic                                 mode_reg, mode_next;
    arq_pkg::level_t                      level_reg, level_next;
    logic                                 brake_reg, brake_next;
    logic                                 announce_reg, announce_next;
    logic [arq_pkg::TIME_WIDTH-1:0]       release_reg, release_next;
    logic [arq_pkg::HOLDOFF_WIDTH-1:0]    holdoff_reg, holdoff_next;

    // output register
    logic                                 out_valid_reg, out_valid_next;
    arq_pkg::grant_t                      o_grant_reg, o_grant_next;
    logic                                 o_mode_reg, o_mode_next;
    arq_pkg::level_t                      o_level_reg, o_level_next;
    logic                                 o_brake_reg, o_brake_next;
    logic                                 o_sound_reg, o_sound_next;
    logic                                 o_refresh_reg, o_refresh_next;
    logic [CNT_WIDTH-1:0]                 o_count_reg, o_count_next;
    logic                                 o_dropped_reg, o_dropped_next;

    // cell row
    arq_pkg::cell_ctrl_t                  cell_ctrl;
    logic [IDX_WIDTH-1:0]                 cell_wpos;
    logic [ID_WIDTH-1:0]                  cell_wr_id;
    arq_pkg::kind_t                       cell_kind [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]                  cell_id [QUEUE_DEPTH];

    logic                                 in_fire;
    logic                                 done_fire;
    logic                                 cfg_write;
    logic                                 head_hit;
    logic                                 head_dup;
    logic [CNT_WIDTH-1:0]                 len_dec;
    logic [CNT_WIDTH-1:0]                 step_inc;
    logic [arq_pkg::TIME_WIDTH-1:0]       since_release;
    logic                                 step_sound;
    logic                                 step_refresh;
    logic                                 step_dropped;

    // row of queue slots, each shifting toward the head
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++)
    begin : g_cell
        arq_pkg::kind_t        nbr_kind;
        logic [ID_WIDTH-1:0]   nbr_id;

        if (gi == QUEUE_DEPTH - 1)
        begin : g_tail
            assign nbr_kind = cell_kind[gi];
            assign nbr_id   = cell_id[gi];
        end
        else
        begin : g_link
            assign nbr_kind = cell_kind[gi+1];
            assign nbr_id   = cell_id[gi+1];
        end

        arq_cell #(
            .ID_WIDTH  (ID_WIDTH),
            .IDX_WIDTH (IDX_WIDTH),
            .IDX       (gi)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .wpos     (cell_wpos),
            .wr_id    (cell_wr_id),
            .nbr_kind (nbr_kind),
            .nbr_id   (nbr_id),
            .kind     (cell_kind[gi]),
            .id       (cell_id[gi])
        );
    end

    // handshakes
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // register read
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == 1'b0)
        begin
            prdata = arq_pkg::PDATA_WIDTH'(holdoff_reg);
        end
    end

    // head compare during the walk
    assign head_hit = (cell_kind[0] == kind_reg) &&
                      ((kind_reg != arq_pkg::KIND_MESSAGE) || (cell_id[0] == id_reg));
    assign head_dup = (cell_kind[0] == kind_reg) && (cell_id[0] == id_reg);
    assign len_dec  = len_reg - CNT_WIDTH'(1);
    assign step_inc = step_reg + CNT_WIDTH'(1);
    assign since_release = now_reg - release_reg;

    // next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        step_next      = step_reg;
        len_next       = len_reg;
        kept_next      = kept_reg;
        found_next     = found_reg;
        fill_next      = fill_reg;
        granted_next   = granted_reg;
        mode_next      = mode_reg;
        level_next     = level_reg;
        brake_next     = brake_reg;
        announce_next  = announce_reg;
        release_next   = release_reg;
        holdoff_next   = holdoff_reg;
        out_valid_next = out_valid_reg;
        o_grant_next   = o_grant_reg;
        o_mode_next    = o_mode_reg;
        o_level_next   = o_level_reg;
        o_brake_next   = o_brake_reg;
        o_sound_next   = o_sound_reg;
        o_refresh_next = o_refresh_reg;
        o_count_next   = o_count_reg;
        o_dropped_next = o_dropped_reg;
        cell_ctrl      = '{pop: 1'b0, push: 1'b0, wr_kind: cell_kind[0]};
        cell_wpos      = len_dec[IDX_WIDTH-1:0];
        cell_wr_id     = cell_id[0];
        step_sound     = 1'b0;
        step_refresh   = 1'b0;
        step_dropped   = 1'b0;

        // configuration write
        if (cfg_write && (paddr[2] == 1'b0))
        begin
            holdoff_next = pwdata[arq_pkg::HOLDOFF_WIDTH-1:0];
        end

        // result taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next  = arq_pkg::kind_t'(ack_kind);
                    id_next    = ack_id;
                    now_next   = time_ms;
                    step_next  = '0;
                    len_next   = fill_reg;
                    kept_next  = 1'b0;
                    found_next = 1'b0;
                    case (req_type)
                        arq_pkg::REQ_TICK:
                        begin
                            op_next = OP_TICK;
                        end
                        arq_pkg::REQ_RAISE:
                        begin
                            // level announce: flag set, all level entries removed
                            if ((arq_pkg::kind_t'(ack_kind) == arq_pkg::KIND_LEVEL) &&
                                (ack_id == ID_WIDTH'(arq_pkg::LEVEL_ID_ANNOUNCE)))
                            begin
                                announce_next = 1'b1;
                                op_next       = OP_REMOVE;
                            end
                            else
                            begin
                                op_next = OP_APPEND;
                            end
                        end
                        arq_pkg::REQ_CLEAR:
                        begin
                            if ((arq_pkg::kind_t'(ack_kind) == arq_pkg::KIND_LEVEL) &&
                                (ack_id == ID_WIDTH'(arq_pkg::LEVEL_ID_REVOKE)))
                            begin
                                announce_next = 1'b0;
                            end
                            op_next = OP_REMOVE;
                        end
                        default:
                        begin
                            op_next = OP_NONE;
                        end
                    endcase
                    if ((req_type == arq_pkg::REQ_RAISE || req_type == arq_pkg::REQ_CLEAR) &&
                        (fill_reg != '0))
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_WALK:
            begin
                // pop the head; push it back at the tail when kept
                cell_ctrl.pop = 1'b1;
                if (op_reg == OP_APPEND)
                begin
                    cell_ctrl.push = 1'b1;
                    if (head_dup)
                    begin
                        found_next = 1'b1;
                    end
                end
                else
                begin
                    cell_ctrl.push = !head_hit;
                    if (head_hit)
                    begin
                        len_next = len_dec;
                        // head entry removed: the grant ends
                        if (!kept_reg)
                        begin
                            case (granted_reg)
                                arq_pkg::GR_MODE:
                                begin
                                    mode_next = 1'b0;
                                end
                                arq_pkg::GR_BRAKE:
                                begin
                                    brake_next = 1'b0;
                                end
                                arq_pkg::GR_LEVEL:
                                begin
                                    level_next = announce_reg ? arq_pkg::LVL_ANNOUNCED
                                                              : arq_pkg::LVL_NONE;
                                end
                                default:
                                begin
                                end
                            endcase
                            release_next = now_reg;
                            granted_next = arq_pkg::GR_NONE;
                        end
                    end
                    else
                    begin
                        kept_next = 1'b1;
                    end
                end
                step_next = step_inc;
                if (step_inc == fill_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (done_fire)
                begin
                    case (op_reg)
                        OP_APPEND:
                        begin
                            if (!found_reg)
                            begin
                                if (fill_reg < CNT_WIDTH'(QUEUE_DEPTH))
                                begin
                                    cell_ctrl.push    = 1'b1;
                                    cell_ctrl.wr_kind = kind_reg;
                                    cell_wpos         = fill_reg[IDX_WIDTH-1:0];
                                    cell_wr_id        = id_reg;
                                    fill_next         = fill_reg + CNT_WIDTH'(1);
                                end
                                else
                                begin
                                    step_dropped = 1'b1;
                                end
                            end
                        end
                        OP_REMOVE:
                        begin
                            fill_next = len_reg;
                        end
                        OP_TICK:
                        begin
                            // grant the head once the hold-off has passed
                            if ((granted_reg == arq_pkg::GR_NONE) && (fill_reg != '0) &&
                                (since_release > arq_pkg::TIME_WIDTH'(holdoff_reg)))
                            begin
                                case (cell_kind[0])
                                    arq_pkg::KIND_MESSAGE:
                                    begin
                                        step_refresh = 1'b1;
                                        granted_next = arq_pkg::GR_MESSAGE;
                                    end
                                    arq_pkg::KIND_MODE:
                                    begin
                                        step_sound   = 1'b1;
                                        mode_next    = 1'b1;
                                        granted_next = arq_pkg::GR_MODE;
                                    end
                                    arq_pkg::KIND_LEVEL:
                                    begin
                                        step_sound   = 1'b1;
                                        level_next   = arq_pkg::LVL_REQUESTED;
                                        granted_next = arq_pkg::GR_LEVEL;
                                    end
                                    default:
                                    begin
                                        step_sound   = 1'b1;
                                        brake_next   = 1'b1;
                                        granted_next = arq_pkg::GR_BRAKE;
                                    end
                                endcase
                            end
                            // level announce indication
                            if (announce_reg)
                            begin
                                if ((granted_next != arq_pkg::GR_MODE) &&
                                    (granted_next != arq_pkg::GR_LEVEL))
                                begin
                                    if (level_next == arq_pkg::LVL_NONE)
                                    begin
                                        step_sound = 1'b1;
                                    end
                                    level_next = arq_pkg::LVL_ANNOUNCED;
                                end
                            end
                            else if (level_next == arq_pkg::LVL_ANNOUNCED)
                            begin
                                level_next = arq_pkg::LVL_NONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_valid_next = 1'b1;
                    o_grant_next   = granted_next;
                    o_mode_next    = mode_next;
                    o_level_next   = level_next;
                    o_brake_next   = brake_next;
                    o_sound_next   = step_sound;
                    o_refresh_next = step_refresh;
                    o_count_next   = fill_next;
                    o_dropped_next = step_dropped;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_NONE;
            step_reg      <= '0;
            len_reg       <= '0;
            kept_reg      <= 1'b0;
            found_reg     <= 1'b0;
            fill_reg      <= '0;
            granted_reg   <= arq_pkg::GR_NONE;
            mode_reg      <= 1'b0;
            level_reg     <= arq_pkg::LVL_NONE;
            brake_reg     <= 1'b0;
            announce_reg  <= 1'b0;
            release_reg   <= '0;
            holdoff_reg   <= arq_pkg::HOLDOFF_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            len_reg       <= len_next;
            kept_reg      <= kept_next;
            found_reg     <= found_next;
            fill_reg      <= fill_next;
            granted_reg   <= granted_next;
            mode_reg      <= mode_next;
            level_reg     <= level_next;
            brake_reg     <= brake_next;
            announce_reg  <= announce_next;
            release_reg   <= release_next;
            holdoff_reg   <= holdoff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item payload and result fields, no reset
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        id_reg        <= id_next;
        now_reg       <= now_next;
        o_grant_reg   <= o_grant_next;
        o_mode_reg    <= o_mode_next;
        o_level_reg   <= o_level_next;
        o_brake_reg   <= o_brake_next;
        o_sound_reg   <= o_sound_next;
        o_refresh_reg <= o_refresh_next;
        o_count_reg   <= o_count_next;
        o_dropped_reg <= o_dropped_next;
    end

    assign out_valid        = out_valid_reg;
    assign allowed_kind     = o_grant_reg;
    assign mode_ack_flag    = o_mode_reg;
    assign level_ack_state  = o_level_reg;
    assign brake_ack_flag   = o_brake_reg;
    assign sound_info       = o_sound_reg;
    assign refresh_messages = o_refresh_reg;
    assign pending_count    = o_count_reg;
    assign dropped          = o_dropped_reg;

endmodule
